// ----- sv/mlt_pkg.sv -----
`default_nettype none

package mlt_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [31:0] LOOPBACK_IP = 32'h7F00_0001;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  localparam logic REQ_SWEEP   = 1'b0;
  localparam logic REQ_OBSERVE = 1'b1;

  typedef enum logic [2:0] {
    OC_UPDATED  = 3'd0,
    OC_INSERTED = 3'd1,
    OC_DROPPED  = 3'd2,
    OC_SKIPPED  = 3'd3,
    OC_SWEEP    = 3'd4
  } outcome_e;

  // one item as it travels down the row of cells
  typedef struct packed {
    logic             valid;
    logic             sweep;
    logic             done;
    logic [47:0]      mac;
    logic [31:0]      ip;
    logic [31:0]      now;
    outcome_e         outcome;
    logic [IDX_W-1:0] slot;
    logic [31:0]      seen;
    logic [31:0]      first;
    logic             act_inc;
    logic             ins;
  } tok_t;

  function automatic logic [5:0] slot6(input logic [IDX_W-1:0] idx);
    logic [IDX_W+5:0] ext;
    ext = {6'b0, idx};
    return ext[5:0];
  endfunction

  function automatic logic [6:0] cnt7(input logic [CNT_W-1:0] c);
    logic [CNT_W+6:0] ext;
    ext = {7'b0, c};
    return ext[6:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/mlt_req_if.sv -----
`default_nettype none

interface mlt_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [47:0] mac_address;
  logic [31:0] ipv4_address;
  logic        entry_complete;
  logic [31:0] time_now;

  modport source (
    output valid, req_type, mac_address, ipv4_address, entry_complete, time_now,
    input  ready
  );
  modport sink (
    input  valid, req_type, mac_address, ipv4_address, entry_complete, time_now,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/mlt_rsp_if.sv -----
`default_nettype none

interface mlt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic [5:0]  slot_index;
  logic [31:0] times_seen;
  logic [31:0] first_seen_time;
  logic [6:0]  active_entries;
  logic [6:0]  stored_entries;

  modport source (
    output valid, outcome, slot_index, times_seen, first_seen_time,
           active_entries, stored_entries,
    input  ready
  );
  modport sink (
    input  valid, outcome, slot_index, times_seen, first_seen_time,
           active_entries, stored_entries,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/mlt_cell.sv -----
`default_nettype none

module mlt_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire logic [mlt_pkg::IDX_W-1:0] idx_i,
  input  wire mlt_pkg::tok_t             tok_i,
  output mlt_pkg::tok_t                  tok_o
);

  logic        used_q, used_d;
  logic        active_q, active_d;
  logic [47:0] mac_q, mac_d;
  logic [31:0] ip_q, ip_d;
  logic [31:0] first_q, first_d;
  logic [31:0] last_q, last_d;
  logic [31:0] cnt_q, cnt_d;
  logic        valid_q;
  mlt_pkg::tok_t tok_q, tok_d;

  logic        hit;
  logic [31:0] cnt_inc;

  assign hit     = used_q && (mac_q == tok_i.mac);
  assign cnt_inc = (cnt_q == mlt_pkg::COUNT_MAX) ? cnt_q : cnt_q + 32'd1;

  always_comb begin
    used_d   = used_q;
    active_d = active_q;
    mac_d    = mac_q;
    ip_d     = ip_q;
    first_d  = first_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    tok_d    = tok_i;
    if (tok_i.valid) begin
      if (tok_i.sweep) begin
        active_d = 1'b0;
      end else if (!tok_i.done) begin
        if (hit) begin
          ip_d          = tok_i.ip;
          last_d        = tok_i.now;
          cnt_d         = cnt_inc;
          active_d      = 1'b1;
          tok_d.done    = 1'b1;
          tok_d.outcome = mlt_pkg::OC_UPDATED;
          tok_d.slot    = idx_i;
          tok_d.seen    = cnt_inc;
          tok_d.first   = first_q;
          tok_d.act_inc = !active_q;
        end else if (!used_q) begin
          // first free slot reached without a match: append here
          used_d        = 1'b1;
          active_d      = 1'b1;
          mac_d         = tok_i.mac;
          ip_d          = tok_i.ip;
          first_d       = tok_i.now;
          last_d        = tok_i.now;
          cnt_d         = 32'd1;
          tok_d.done    = 1'b1;
          tok_d.outcome = mlt_pkg::OC_INSERTED;
          tok_d.slot    = idx_i;
          tok_d.seen    = 32'd1;
          tok_d.first   = tok_i.now;
          tok_d.act_inc = 1'b1;
          tok_d.ins     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= 1'b0;
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else if (adv_i) begin
      used_q   <= used_d;
      active_q <= active_d;
      valid_q  <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mac_q   <= mac_d;
      ip_q    <= ip_d;
      first_q <= first_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
      tok_q   <= tok_d;
    end
  end

  // valid comes from the reset register, the rest from the payload register
  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ----- sv/mac_learning_table.sv -----
// mac learning table: neighbor entries keyed by 48-bit mac, filled in arrival order
//
// channels: req_i (sink) takes one beat per item: a sweep start (req_type 0) clears
// every active mark, an observed entry (req_type 1) is looked up and either updates
// its slot, is appended, is dropped when the table is full, or is skipped when it is
// incomplete or carries the loopback address. rsp_o (source) returns one beat per
// item with the outcome, slot, count, first-seen time and the active/stored totals.
//
// structure: a row of ENTRIES cells, one table slot each. every item walks the row
// one cell per cycle; the first cell holding its mac updates it, the first empty cell
// appends it. totals are kept in order at the end of the row.
// path: a req beat passes the ENTRIES cell registers, then the response register, to its rsp beat.
// throughput: one item per cycle while rsp_o is not stalled, set by the one-cell-per-cycle advance of the row.
//
// reset clears every slot's used and active marks and both totals; the table is
// usable straight after reset. when rsp_o is stalled the whole row holds,
// and req_i.ready drops until the waiting response beat is taken.
`default_nettype none

module mac_learning_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mlt_req_if.sink   req_i,
  mlt_rsp_if.source rsp_o
);

  localparam int unsigned IW = mlt_pkg::IDX_W;

  // row advances whenever the output register is free or being emptied
  logic adv;

  mlt_pkg::tok_t chain [mlt_pkg::ENTRIES+1];
  mlt_pkg::tok_t tok_in;
  mlt_pkg::tok_t tail;

  logic filtered;
  logic is_sweep;

  // response register and running totals
  logic                        out_valid_q;
  logic [2:0]                  outcome_q;
  logic [5:0]                  slot_q;
  logic [31:0]                 seen_q;
  logic [31:0]                 first_q;
  logic [6:0]                  act_out_q;
  logic [6:0]                  sto_out_q;
  logic [mlt_pkg::CNT_W-1:0]   active_cnt_q, active_cnt_d;
  logic [mlt_pkg::CNT_W-1:0]   stored_cnt_q, stored_cnt_d;

  assign adv         = !out_valid_q || rsp_o.ready;
  assign req_i.ready = adv;

  // classify the incoming beat before it enters the row
  assign is_sweep = (req_i.req_type == mlt_pkg::REQ_SWEEP);
  assign filtered = !req_i.entry_complete || (req_i.ipv4_address == mlt_pkg::LOOPBACK_IP);

  always_comb begin
    tok_in         = '0;
    tok_in.valid   = req_i.valid;
    tok_in.sweep   = is_sweep;
    tok_in.done    = !is_sweep && filtered;
    tok_in.mac     = req_i.mac_address;
    tok_in.ip      = req_i.ipv4_address;
    tok_in.now     = req_i.time_now;
    // an observed entry that leaves the row untouched was dropped: table full
    if (is_sweep) begin
      tok_in.outcome = mlt_pkg::OC_SWEEP;
    end else if (filtered) begin
      tok_in.outcome = mlt_pkg::OC_SKIPPED;
    end else begin
      tok_in.outcome = mlt_pkg::OC_DROPPED;
    end
  end

  assign chain[0] = tok_in;

  for (genvar g = 0; g < mlt_pkg::ENTRIES; g++) begin : g_cell
    mlt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .idx_i  (IW'(g)),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  assign tail = chain[mlt_pkg::ENTRIES];

  // totals follow items in order as they leave the row
  always_comb begin
    active_cnt_d = active_cnt_q;
    stored_cnt_d = stored_cnt_q;
    if (tail.valid) begin
      if (tail.sweep) begin
        active_cnt_d = '0;
      end else begin
        if (tail.act_inc) begin
          active_cnt_d = active_cnt_q + mlt_pkg::CNT_W'(1);
        end
        if (tail.ins) begin
          stored_cnt_d = stored_cnt_q + mlt_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      active_cnt_q <= '0;
      stored_cnt_q <= '0;
    end else if (adv) begin
      out_valid_q  <= tail.valid;
      active_cnt_q <= active_cnt_d;
      stored_cnt_q <= stored_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail.valid) begin
      outcome_q <= tail.outcome;
      slot_q    <= mlt_pkg::slot6(tail.slot);
      seen_q    <= tail.seen;
      first_q   <= tail.first;
      act_out_q <= mlt_pkg::cnt7(active_cnt_d);
      sto_out_q <= mlt_pkg::cnt7(stored_cnt_d);
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.outcome         = outcome_q;
  assign rsp_o.slot_index      = slot_q;
  assign rsp_o.times_seen      = seen_q;
  assign rsp_o.first_seen_time = first_q;
  assign rsp_o.active_entries  = act_out_q;
  assign rsp_o.stored_entries  = sto_out_q;

  // active slots are always a subset of stored slots
  a_active_le_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_cnt_q <= stored_cnt_q)
    else $error("active total exceeds stored total");

  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_cnt_q <= mlt_pkg::CNT_W'(mlt_pkg::ENTRIES))
    else $error("stored total beyond table size");

  a_stored_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> stored_cnt_q >= $past(stored_cnt_q))
    else $error("stored total went down");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && outcome_q == mlt_pkg::OC_DROPPED)
      |-> stored_cnt_q == mlt_pkg::CNT_W'(mlt_pkg::ENTRIES))
    else $error("entry dropped while table has room");

  a_sweep_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && outcome_q == mlt_pkg::OC_SWEEP) |-> act_out_q == 7'd0)
    else $error("sweep left active entries");

endmodule

`default_nettype wire

// ----- tb/tb_mac_learning_table.sv -----
`default_nettype none

module tb_mac_learning_table;

  // run shape
  localparam int unsigned RANDOM_ITEMS = 1532;
  localparam int unsigned POOL_SIZE    = 80;
  localparam int unsigned SCRIPT_LEN   = 18;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned DRAIN_CYCLES = mlt_pkg::ENTRIES + 16;
  localparam int unsigned LIMIT_CYCLES = 300000;

  // one sighting as offered on the request channel
  typedef struct packed {
    logic        req_type;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        complete;
    logic [31:0] now;
  } sighting_t;

  // one response beat as the table should report it
  typedef struct packed {
    mlt_pkg::outcome_e outcome;
    logic [5:0]        slot;
    logic [31:0]       seen;
    logic [31:0]       first;
    logic [6:0]        active;
    logic [6:0]        stored;
  } verdict_t;

  // directed row: stimulus plus an optional hand-written response
  typedef struct packed {
    sighting_t stim;
    bit        typed;
    verdict_t  want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mlt_req_if req_bus ();
  mlt_rsp_if rsp_bus ();

  mac_learning_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // 4 time unit clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the learned neighbors
  logic [47:0]                 mac_tab   [mlt_pkg::ENTRIES];
  logic [31:0]                 first_tab [mlt_pkg::ENTRIES];
  logic [31:0]                 seen_tab  [mlt_pkg::ENTRIES];
  bit   [mlt_pkg::ENTRIES-1:0] active_mark;
  int unsigned                 stored_total;
  int unsigned                 active_total;

  verdict_t    pending_rsp [$];
  int unsigned items_sent;
  int unsigned beats_taken;
  int unsigned mismatches;

  // applies one sighting to the shadow table and returns the response it earns
  function automatic verdict_t learn_sighting(input sighting_t s);
    verdict_t v;
    int       hit;
    int       i;
    v.outcome = mlt_pkg::OC_SKIPPED;
    v.slot    = '0;
    v.seen    = '0;
    v.first   = '0;
    hit       = -1;
    if (s.req_type == mlt_pkg::REQ_SWEEP) begin
      // new sweep: nobody counts as active until seen again
      active_mark  = '0;
      active_total = 0;
      v.outcome    = mlt_pkg::OC_SWEEP;
    end else if (s.complete == 1'b0 || s.ip == mlt_pkg::LOOPBACK_IP) begin
      // incomplete or loopback sightings leave the table alone
      v.outcome = mlt_pkg::OC_SKIPPED;
    end else begin
      // first stored slot holding this mac wins
      for (i = 0; i < int'(stored_total); i++) begin
        if (hit < 0 && mac_tab[i] == s.mac) hit = i;
      end
      if (hit >= 0) begin
        if (seen_tab[hit] != mlt_pkg::COUNT_MAX) seen_tab[hit] = seen_tab[hit] + 32'd1;
        if (!active_mark[hit]) begin
          active_mark[hit] = 1'b1;
          active_total++;
        end
        v.outcome = mlt_pkg::OC_UPDATED;
        v.slot    = hit[5:0];
        v.seen    = seen_tab[hit];
        v.first   = first_tab[hit];
      end else if (stored_total < mlt_pkg::ENTRIES) begin
        // miss with room left: append in arrival order
        hit              = int'(stored_total);
        mac_tab[hit]     = s.mac;
        first_tab[hit]   = s.now;
        seen_tab[hit]    = 32'd1;
        active_mark[hit] = 1'b1;
        active_total++;
        stored_total++;
        v.outcome = mlt_pkg::OC_INSERTED;
        v.slot    = hit[5:0];
        v.seen    = 32'd1;
        v.first   = s.now;
      end else begin
        // full table: sighting is lost
        v.outcome = mlt_pkg::OC_DROPPED;
      end
    end
    v.active = active_total[6:0];
    v.stored = stored_total[6:0];
    return v;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at beat %0d: %s got 0x%0h want 0x%0h", beats_taken, field, got, want);
    mismatches++;
  endtask

  // offers one request beat, then books the expected response at its acceptance
  task automatic offer_item(input sighting_t s, input bit typed, input verdict_t want);
    int unsigned gap;
    verdict_t    v;
    // every third stretch of 100 items goes back to back
    gap = (((items_sent / 100) % 3) == 1) ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk_i);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_bus.valid          <= 1'b1;
    req_bus.req_type       <= s.req_type;
    req_bus.mac_address    <= s.mac;
    req_bus.ipv4_address   <= s.ip;
    req_bus.entry_complete <= s.complete;
    req_bus.time_now       <= s.now;
    @(posedge clk_i);
    while (req_bus.ready !== 1'b1) @(posedge clk_i);
    // shadow state always advances; a hand-written row overrides the prediction
    v = learn_sighting(s);
    pending_rsp.push_back(typed ? want : v);
    items_sent++;
  endtask

  // response side: random stalls, two long hold-offs to back the row up
  initial begin
    verdict_t    want;
    int unsigned gap;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = (((beats_taken / 90) % 3) == 2) ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
        @(negedge clk_i);
        rsp_bus.ready <= 1'b0;
      end
      @(negedge clk_i);
      rsp_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (rsp_bus.valid !== 1'b1) @(posedge clk_i);
      if (pending_rsp.size() == 0) begin
        note_mismatch("unexpected beat, outcome", 64'(rsp_bus.outcome), 64'h0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.outcome !== want.outcome)
          note_mismatch("outcome", 64'(rsp_bus.outcome), 64'(want.outcome));
        if (rsp_bus.slot_index !== want.slot)
          note_mismatch("slot_index", 64'(rsp_bus.slot_index), 64'(want.slot));
        if (rsp_bus.times_seen !== want.seen)
          note_mismatch("times_seen", 64'(rsp_bus.times_seen), 64'(want.seen));
        if (rsp_bus.first_seen_time !== want.first)
          note_mismatch("first_seen_time", 64'(rsp_bus.first_seen_time), 64'(want.first));
        if (rsp_bus.active_entries !== want.active)
          note_mismatch("active_entries", 64'(rsp_bus.active_entries), 64'(want.active));
        if (rsp_bus.stored_entries !== want.stored)
          note_mismatch("stored_entries", 64'(rsp_bus.stored_entries), 64'(want.stored));
      end
      beats_taken++;
      // long hold-off while the sender keeps offering, so req ready must drop
      if (beats_taken == 400 || beats_taken == 1200) begin
        @(negedge clk_i);
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
    end
  end

  // hard stop
  initial begin
    #(LIMIT_CYCLES * 4);
    $display("simulation failed");
    $finish;
  end

  initial begin
    script_row_t script [SCRIPT_LEN];
    logic [47:0] mac_pool [POOL_SIZE];
    sighting_t   s;
    int unsigned k;
    int unsigned roll;
    int unsigned window;
    int unsigned useful;

    rst_ni                 <= 1'b0;
    req_bus.valid          <= 1'b0;
    req_bus.req_type       <= mlt_pkg::REQ_SWEEP;
    req_bus.mac_address    <= '0;
    req_bus.ipv4_address   <= '0;
    req_bus.entry_complete <= 1'b0;
    req_bus.time_now       <= '0;
    active_mark  = '0;
    stored_total = 0;
    active_total = 0;
    items_sent   = 0;
    beats_taken  = 0;
    mismatches   = 0;
    useful       = 0;

    // directed rows; hand-written responses where they are obvious
    // sweep on an empty table, junk in the ignored fields
    script[0]  = '{'{mlt_pkg::REQ_SWEEP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                     32'hFFFF_FFFF},
                   1'b1, '{mlt_pkg::OC_SWEEP, 6'd0, 32'd0, 32'd0, 7'd0, 7'd0}};
    // incomplete entry is filtered
    script[1]  = '{'{mlt_pkg::REQ_OBSERVE, 48'h0, 32'h0, 1'b0, 32'h0},
                   1'b1, '{mlt_pkg::OC_SKIPPED, 6'd0, 32'd0, 32'd0, 7'd0, 7'd0}};
    // loopback address is filtered
    script[2]  = '{'{mlt_pkg::REQ_OBSERVE, 48'h0, mlt_pkg::LOOPBACK_IP, 1'b1, 32'h0},
                   1'b1, '{mlt_pkg::OC_SKIPPED, 6'd0, 32'd0, 32'd0, 7'd0, 7'd0}};
    // all-zero mac lands in slot 0
    script[3]  = '{'{mlt_pkg::REQ_OBSERVE, 48'h0, 32'h0, 1'b1, 32'h0},
                   1'b1, '{mlt_pkg::OC_INSERTED, 6'd0, 32'd1, 32'd0, 7'd1, 7'd1}};
    // all-ones everything lands in slot 1
    script[4]  = '{'{mlt_pkg::REQ_OBSERVE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                     32'hFFFF_FFFF},
                   1'b1, '{mlt_pkg::OC_INSERTED, 6'd1, 32'd1, 32'hFFFF_FFFF, 7'd2, 7'd2}};
    // repeat within one sweep: count grows, active total does not
    script[5]  = '{'{mlt_pkg::REQ_OBSERVE, 48'h0, 32'h0102_0304, 1'b1, 32'd5},
                   1'b1, '{mlt_pkg::OC_UPDATED, 6'd0, 32'd2, 32'd0, 7'd2, 7'd2}};
    script[6]  = '{'{mlt_pkg::REQ_SWEEP, 48'h0, 32'h0, 1'b0, 32'h0},
                   1'b1, '{mlt_pkg::OC_SWEEP, 6'd0, 32'd0, 32'd0, 7'd0, 7'd2}};
    // re-seen after a sweep: active again, first-seen time kept
    script[7]  = '{'{mlt_pkg::REQ_OBSERVE, 48'hFFFF_FFFF_FFFF, 32'h0A00_0001, 1'b1, 32'd7},
                   1'b1, '{mlt_pkg::OC_UPDATED, 6'd1, 32'd2, 32'hFFFF_FFFF, 7'd1, 7'd2}};
    // addresses right next to loopback pass the filter
    script[8]  = '{'{mlt_pkg::REQ_OBSERVE, 48'h0000_0000_0001, 32'h7F00_0000, 1'b1, 32'd100},
                   1'b0, '0};
    script[9]  = '{'{mlt_pkg::REQ_OBSERVE, 48'h8000_0000_0000, 32'h7F00_0002, 1'b1, 32'd200},
                   1'b0, '0};
    // filtered sightings of known macs change nothing
    script[10] = '{'{mlt_pkg::REQ_OBSERVE, 48'hFFFF_FFFF_FFFF, mlt_pkg::LOOPBACK_IP, 1'b0,
                     32'd300}, 1'b0, '0};
    script[11] = '{'{mlt_pkg::REQ_OBSERVE, 48'h0, 32'h0102_0304, 1'b0, 32'd301}, 1'b0, '0};
    script[12] = '{'{mlt_pkg::REQ_OBSERVE, 48'h0, mlt_pkg::LOOPBACK_IP, 1'b1, 32'd302},
                   1'b0, '0};
    script[13] = '{'{mlt_pkg::REQ_SWEEP, 48'h1234_5678_9ABC, 32'h0, 1'b1, 32'd303}, 1'b0, '0};
    script[14] = '{'{mlt_pkg::REQ_OBSERVE, 48'h0000_0000_0001, 32'hC0A8_0001, 1'b1, 32'd400},
                   1'b0, '0};
    script[15] = '{'{mlt_pkg::REQ_OBSERVE, 48'h0000_0000_0001, 32'hC0A8_0002, 1'b1, 32'd401},
                   1'b0, '0};
    // alternating bit patterns
    script[16] = '{'{mlt_pkg::REQ_OBSERVE, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b1,
                     32'hAAAA_AAAA}, 1'b0, '0};
    script[17] = '{'{mlt_pkg::REQ_OBSERVE, 48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b1,
                     32'h5555_5555}, 1'b0, '0};

    for (k = 0; k < POOL_SIZE; k++) begin
      mac_pool[k] = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom())};
    end

    // asynchronous reset, released on a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < SCRIPT_LEN; k++) begin
      offer_item(script[k].stim, script[k].typed, script[k].want);
    end

    // random part: a growing set of known macs so hits dominate early and
    // the table fills and starts dropping later; sweeps and filtered noise mixed in
    while (useful < RANDOM_ITEMS) begin
      roll   = $urandom_range(0, 99);
      window = 16 + useful / 16;
      if (window > POOL_SIZE) window = POOL_SIZE;
      s.req_type = mlt_pkg::REQ_OBSERVE;
      s.mac      = mac_pool[$urandom_range(0, window - 1)];
      s.ip       = $urandom();
      s.complete = 1'b1;
      s.now      = $urandom();
      if (roll < 8) begin
        s.req_type = mlt_pkg::REQ_SWEEP;
        s.complete = 1'($urandom_range(0, 1));
      end else if (roll < 12) begin
        s.complete = 1'b0;
      end else if (roll < 16) begin
        s.ip = mlt_pkg::LOOPBACK_IP;
      end else if (roll < 20) begin
        // never-seen mac
        s.mac = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom())};
      end
      useful++;
      offer_item(s, 1'b0, '0);
    end

    @(negedge clk_i);
    req_bus.valid <= 1'b0;

    // wait for every booked response, then for anything stray to show up
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
